// ----- design/bkn_pkg.sv -----
// Shared types, constants and glyph table for the kanji numeral speller.
// No dependencies; used by bkn_bcd, bkn_spell and binary_to_kanji_numeral.
package bkn_pkg;

    localparam int VALUE_W  = 32;
    localparam int DIGITS   = 10;
    localparam int BCD_W    = 4 * DIGITS;
    localparam int CNT_W    = $clog2(VALUE_W);
    localparam int POS_W    = $clog2(DIGITS);
    localparam int SYM_W    = 4;
    localparam int GLYPH_W  = 13;
    localparam int OUT_W    = 24;
    localparam int GLYPH_OFS = 911;

    // symbol codes
    localparam logic [SYM_W-1:0] SYM_ZERO     = 4'd0;
    localparam logic [SYM_W-1:0] SYM_ONE      = 4'd1;
    localparam logic [SYM_W-1:0] SYM_TEN      = 4'd10;
    localparam logic [SYM_W-1:0] SYM_HUNDRED  = 4'd11;
    localparam logic [SYM_W-1:0] SYM_THOUSAND = 4'd12;
    localparam logic [SYM_W-1:0] SYM_MAN      = 4'd13;
    localparam logic [SYM_W-1:0] SYM_OKU      = 4'd14;
    localparam logic [SYM_W-1:0] SYM_TWENTY   = 4'd15;

    // bcd pattern of the value twenty
    localparam logic [BCD_W-1:0] BCD_TWENTY = 40'h20;

    // one symbol handed from the speller to the output register
    typedef struct packed {
        logic             valid;
        logic [SYM_W-1:0] sym;
        logic             last;
    } push_t;

    // font table index of each symbol's glyph
    function automatic logic [GLYPH_W-1:0] glyph_of(input logic [SYM_W-1:0] sym);
        logic [GLYPH_W-1:0] base;
        begin
            unique case (sym)
                4'd0:    base = 13'd3395;
                4'd1:    base = 13'd574;
                4'd2:    base = 13'd2649;
                4'd3:    base = 13'd1548;
                4'd4:    base = 13'd1577;
                4'd5:    base = 13'd1312;
                4'd6:    base = 13'd3439;
                4'd7:    base = 13'd1649;
                4'd8:    base = 13'd2766;
                4'd9:    base = 13'd1131;
                4'd10:   base = 13'd1749;
                4'd11:   base = 13'd2868;
                4'd12:   base = 13'd2075;
                4'd13:   base = 13'd3128;
                4'd14:   base = 13'd701;
                default: base = 13'd2657;
            endcase
            glyph_of = base + GLYPH_W'(GLYPH_OFS);
        end
    endfunction

endpackage

// ----- design/bkn_bcd.sv -----
// Iterative binary to bcd converter: one shift-and-correct step per cycle.
// Depends on bkn_pkg for widths.
module bkn_bcd (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [bkn_pkg::VALUE_W-1:0] value,
    output logic                        busy,
    output logic                        done,
    output logic [bkn_pkg::BCD_W-1:0]   bcd
);

    logic [bkn_pkg::VALUE_W-1:0] bin_reg;
    logic [bkn_pkg::VALUE_W-1:0] bin_next;
    logic [bkn_pkg::BCD_W-1:0]   bcd_reg;
    logic [bkn_pkg::BCD_W-1:0]   bcd_next;
    logic [bkn_pkg::BCD_W-1:0]   adj;
    logic [bkn_pkg::CNT_W-1:0]   cnt_reg;
    logic                        busy_reg;
    logic                        done_reg;

    // add-3 correction on every digit, then shift one binary bit in
    always_comb
    begin
        for (int i = 0; i < bkn_pkg::DIGITS; i++)
        begin
            if (bcd_reg[i*4 +: 4] >= 4'd5)
                adj[i*4 +: 4] = bcd_reg[i*4 +: 4] + 4'd3;
            else
                adj[i*4 +: 4] = bcd_reg[i*4 +: 4];
        end
        bcd_next = {adj[bkn_pkg::BCD_W-2:0], bin_reg[bkn_pkg::VALUE_W-1]};
        bin_next = {bin_reg[bkn_pkg::VALUE_W-2:0], 1'b0};
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + bkn_pkg::CNT_W'(1);
            if (cnt_reg == bkn_pkg::CNT_W'(bkn_pkg::VALUE_W - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            bin_reg <= value;
            bcd_reg <= '0;
        end
        else if (busy_reg)
        begin
            bin_reg <= bin_next;
            bcd_reg <= bcd_next;
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign bcd  = bcd_reg;

`ifndef SYNTHESIS
    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy_reg)
        else $error("bcd done while still converting");
`endif

endmodule

// ----- design/bkn_spell.sv -----
// Digit walker: turns ten bcd digits into the run of numeral symbols.
// Depends on bkn_pkg for symbol codes and the push_t struct.
module bkn_spell (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      load,
    input  logic [bkn_pkg::BCD_W-1:0] bcd,
    input  logic                      out_free,
    output logic                      busy,
    output bkn_pkg::push_t            push
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_RUN   = 2'd1;
    localparam logic [1:0] ST_FLUSH = 2'd2;

    localparam logic [1:0] PH_DIGIT = 2'd0;
    localparam logic [1:0] PH_PLACE = 2'd1;
    localparam logic [1:0] PH_BIG   = 2'd2;

    localparam logic [bkn_pkg::POS_W-1:0] POS_TOP = bkn_pkg::POS_W'(bkn_pkg::DIGITS - 1);
    localparam logic [bkn_pkg::POS_W-1:0] POS_OKU = bkn_pkg::POS_W'(8);

    logic [1:0]                       state_reg;
    logic [1:0]                       state_next;
    logic [1:0]                       phase_reg;
    logic [1:0]                       phase_next;
    logic [bkn_pkg::POS_W-1:0]        pos_reg;
    logic [bkn_pkg::POS_W-1:0]        pos_next;
    logic [bkn_pkg::BCD_W-1:0]        digits_reg;
    logic                             pend_valid_reg;
    logic                             pend_valid_next;
    logic [bkn_pkg::SYM_W-1:0]        pend_sym_reg;
    logic [bkn_pkg::SYM_W-1:0]        pend_sym_next;

    logic [3:0]                       digit;
    logic [1:0]                       grp_pos;
    logic                             group_nz;
    logic                             gen_valid;
    logic [bkn_pkg::SYM_W-1:0]        gen_sym;
    logic [bkn_pkg::SYM_W-1:0]        place_sym;
    logic                             stall;

    // current digit and its place inside a four-digit group
    assign digit  = digits_reg[{pos_reg, 2'b00} +: 4];
    assign grp_pos = pos_reg[1:0];
    assign group_nz = (pos_reg == POS_OKU) ? (|digits_reg[39:32]) : (|digits_reg[31:16]);

    always_comb
    begin
        unique case (grp_pos)
            2'd1:    place_sym = bkn_pkg::SYM_TEN;
            2'd2:    place_sym = bkn_pkg::SYM_HUNDRED;
            2'd3:    place_sym = bkn_pkg::SYM_THOUSAND;
            default: place_sym = bkn_pkg::SYM_TEN;
        endcase
    end

    // symbol produced at this step, if any
    always_comb
    begin
        gen_valid = 1'b0;
        gen_sym   = digit;
        unique case (phase_reg)
            PH_DIGIT:
            begin
                gen_valid = (digit != 4'd0) && ((grp_pos == 2'd0) || (digit != 4'd1));
                gen_sym   = digit;
            end
            PH_PLACE:
            begin
                gen_valid = (digit != 4'd0) && (grp_pos != 2'd0);
                gen_sym   = place_sym;
            end
            PH_BIG:
            begin
                gen_valid = (grp_pos == 2'd0) && (pos_reg != '0) && group_nz;
                gen_sym   = (pos_reg == POS_OKU) ? bkn_pkg::SYM_OKU : bkn_pkg::SYM_MAN;
            end
            default:
            begin
                gen_valid = 1'b0;
                gen_sym   = digit;
            end
        endcase
    end

    // a new symbol can only be taken when the held one can leave
    assign stall = (state_reg == ST_RUN) && gen_valid && pend_valid_reg && !out_free;

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        phase_next      = phase_reg;
        pos_next        = pos_reg;
        pend_valid_next = pend_valid_reg;
        pend_sym_next   = pend_sym_reg;
        push.valid      = 1'b0;
        push.sym        = pend_sym_reg;
        push.last       = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (load)
                begin
                    pos_next   = POS_TOP;
                    phase_next = PH_DIGIT;
                    if (bcd == '0)
                    begin
                        pend_valid_next = 1'b1;
                        pend_sym_next   = bkn_pkg::SYM_ZERO;
                        state_next      = ST_FLUSH;
                    end
                    else if (bcd == bkn_pkg::BCD_TWENTY)
                    begin
                        pend_valid_next = 1'b1;
                        pend_sym_next   = bkn_pkg::SYM_TWENTY;
                        state_next      = ST_FLUSH;
                    end
                    else
                    begin
                        pend_valid_next = 1'b0;
                        state_next      = ST_RUN;
                    end
                end
            end
            ST_RUN:
            begin
                if (!stall)
                begin
                    if (gen_valid)
                    begin
                        push.valid      = pend_valid_reg;
                        pend_valid_next = 1'b1;
                        pend_sym_next   = gen_sym;
                    end
                    if (phase_reg == PH_BIG)
                    begin
                        phase_next = PH_DIGIT;
                        if (pos_reg == '0)
                            state_next = ST_FLUSH;
                        else
                            pos_next = pos_reg - bkn_pkg::POS_W'(1);
                    end
                    else
                    begin
                        phase_next = phase_reg + 2'd1;
                    end
                end
            end
            ST_FLUSH:
            begin
                if (out_free)
                begin
                    push.valid      = 1'b1;
                    push.last       = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            phase_reg      <= PH_DIGIT;
            pos_reg        <= '0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            phase_reg      <= phase_next;
            pos_reg        <= pos_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        pend_sym_reg <= pend_sym_next;
        if (load && (state_reg == ST_IDLE))
            digits_reg <= bcd;
    end

    assign busy = (state_reg != ST_IDLE);

`ifndef SYNTHESIS
    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        push.valid |-> out_free)
        else $error("symbol pushed into a full output register");

    a_flush_pending: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_FLUSH) |-> pend_valid_reg)
        else $error("run ends with no symbol held");

    a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
        load |-> (state_reg == ST_IDLE))
        else $error("digits loaded while a run is in progress");
`endif

endmodule

// ----- design/binary_to_kanji_numeral.sv -----
// Spells a 32-bit unsigned value as a run of kanji numeral symbols.
// The first symbol is delayed by leading zero digits; the last one leaves in the flush.
// One value at a time: 32 double-dabble steps in bkn_bcd, a load step, a 30-step walk
// over ten digits (three phases each; zero and twenty skip it), then a flush.
// Output back-pressure can hold the walk and the flush.
// Reset is asynchronous, active low, control only.
module binary_to_kanji_numeral (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [bkn_pkg::VALUE_W-1:0] s_tdata,  // [31:0] value
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [bkn_pkg::OUT_W-1:0]   m_tdata,  // [3:0] symbol, [16:4] glyph_index, zero pad
    output logic                        m_tlast
);

    logic                        bcd_start;
    logic                        bcd_busy;
    logic                        bcd_done;
    logic [bkn_pkg::BCD_W-1:0]   bcd_val;
    logic                        spell_busy;
    logic                        out_free;
    bkn_pkg::push_t              push;

    logic                        m_tvalid_reg;
    logic [bkn_pkg::SYM_W-1:0]   sym_reg;
    logic                        last_reg;

    // input side takes a new value only when both units are free
    assign s_tready  = !bcd_busy && !bcd_done && !spell_busy;
    assign bcd_start = s_tvalid && s_tready;

    bkn_bcd u_bcd (
        .clk   (clk),
        .rst_n (rst_n),
        .start (bcd_start),
        .value (s_tdata),
        .busy  (bcd_busy),
        .done  (bcd_done),
        .bcd   (bcd_val)
    );

    bkn_spell u_spell (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (bcd_done),
        .bcd      (bcd_val),
        .out_free (out_free),
        .busy     (spell_busy),
        .push     (push)
    );

    // output register
    assign out_free = !m_tvalid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tvalid_reg <= 1'b0;
        else if (push.valid)
            m_tvalid_reg <= 1'b1;
        else if (m_tready)
            m_tvalid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (push.valid)
        begin
            sym_reg  <= push.sym;
            last_reg <= push.last;
        end
    end

    // glyph lookup on the held symbol
    assign m_tvalid = m_tvalid_reg;
    assign m_tlast  = last_reg;
    assign m_tdata  = {{(bkn_pkg::OUT_W - bkn_pkg::GLYPH_W - bkn_pkg::SYM_W){1'b0}},
                       bkn_pkg::glyph_of(sym_reg), sym_reg};

`ifndef SYNTHESIS
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("second value taken while one is in progress");
`endif

endmodule

// ----- tb/sv/kanji_run_checker.sv -----
// Checker for binary_to_kanji_numeral: watches both stream channels, spells each
// accepted value into its expected symbol run and compares every output transfer.
// Depends on bkn_pkg for widths and symbol codes.
module kanji_run_checker (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_tvalid,
    input  logic                        s_tready,
    input  logic [bkn_pkg::VALUE_W-1:0] s_tdata,  // [31:0] value
    input  logic                        m_tvalid,
    input  logic                        m_tready,
    input  logic [bkn_pkg::OUT_W-1:0]   m_tdata,  // [3:0] symbol, [16:4] glyph_index, zero pad
    input  logic                        m_tlast,
    output int                          mismatches,
    output int                          pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import bkn_pkg::*;

    localparam int MAX_RUN = 20;
    localparam int FONT_OFFSET = 911;
    localparam int unsigned MAN_VALUE = 10000;
    localparam int unsigned OKU_VALUE = 100000000;

    typedef struct {
        logic [VALUE_W-1:0] value;
        logic [SYM_W-1:0]   sym;
        logic [GLYPH_W-1:0] glyph;
        logic               last;
    } numeral_t;

    // font index of each symbol code
    logic [GLYPH_W-1:0] glyph_table [16] = '{
        GLYPH_W'(3395 + FONT_OFFSET), GLYPH_W'(574 + FONT_OFFSET),
        GLYPH_W'(2649 + FONT_OFFSET), GLYPH_W'(1548 + FONT_OFFSET),
        GLYPH_W'(1577 + FONT_OFFSET), GLYPH_W'(1312 + FONT_OFFSET),
        GLYPH_W'(3439 + FONT_OFFSET), GLYPH_W'(1649 + FONT_OFFSET),
        GLYPH_W'(2766 + FONT_OFFSET), GLYPH_W'(1131 + FONT_OFFSET),
        GLYPH_W'(1749 + FONT_OFFSET), GLYPH_W'(2868 + FONT_OFFSET),
        GLYPH_W'(2075 + FONT_OFFSET), GLYPH_W'(3128 + FONT_OFFSET),
        GLYPH_W'(701 + FONT_OFFSET),  GLYPH_W'(2657 + FONT_OFFSET)
    };

    numeral_t         expected_symbols [$];
    logic [SYM_W-1:0] spelled [$];

    function automatic void put_symbol(input logic [SYM_W-1:0] s);
        if (spelled.size() < MAX_RUN)
            spelled.push_back(s);
    endfunction

    // spell a group 1..9999: a leading one is dropped before ten, hundred, thousand
    function automatic void spell_group(input int unsigned g);
        int unsigned scale;
        int unsigned d;
        logic [SYM_W-1:0] unit_sym;
        scale = 1000;
        repeat (3)
        begin
            d = (g / scale) % 10;
            unit_sym = (scale == 1000) ? SYM_THOUSAND : (scale == 100) ? SYM_HUNDRED : SYM_TEN;
            if (d > 1)
                put_symbol(SYM_W'(d));
            if (d != 0)
                put_symbol(unit_sym);
            scale = scale / 10;
        end
        d = g % 10;
        if (d != 0)
            put_symbol(SYM_W'(d));
    endfunction

    // full run for one value; factors of man and oku are always written, even one
    function automatic void spell_value(input logic [VALUE_W-1:0] v);
        int unsigned oku;
        int unsigned man;
        int unsigned low;
        numeral_t n;
        spelled.delete();
        oku = v / OKU_VALUE;
        man = (v / MAN_VALUE) % MAN_VALUE;
        low = v % MAN_VALUE;
        if (v == 0)
            put_symbol(SYM_ZERO);
        else if (v == 20)
            put_symbol(SYM_TWENTY);
        else
        begin
            if (oku != 0)
            begin
                spell_group(oku);
                put_symbol(SYM_OKU);
            end
            if (man != 0)
            begin
                spell_group(man);
                put_symbol(SYM_MAN);
            end
            if (low != 0)
                spell_group(low);
        end
        foreach (spelled[k])
        begin
            n.value = v;
            n.sym = spelled[k];
            n.glyph = glyph_table[spelled[k]];
            n.last = (k == spelled.size() - 1);
            expected_symbols.push_back(n);
        end
    endfunction

    function automatic void note_mismatch(input string detail);
        if (mismatches < 10)
            $display("kanji_run_checker: %s at %0t", detail, $realtime);
        mismatches++;
    endfunction

    // output transfers are checked before the input transfer of the same edge is predicted
    always @(posedge clk)
    begin
        numeral_t want;
        logic [SYM_W-1:0] got_sym;
        logic [GLYPH_W-1:0] got_glyph;
        if (!rst_n)
        begin
            mismatches = 0;
            pending = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got_sym = m_tdata[SYM_W-1:0];
                got_glyph = m_tdata[SYM_W +: GLYPH_W];
                if (expected_symbols.size() == 0)
                    note_mismatch($sformatf("unexpected symbol %0d glyph %0d last %0b",
                                            got_sym, got_glyph, m_tlast));
                else
                begin
                    want = expected_symbols.pop_front();
                    if (got_sym != want.sym)
                        note_mismatch($sformatf("value %0d symbol: expected %0d got %0d",
                                                want.value, want.sym, got_sym));
                    if (got_glyph != want.glyph)
                        note_mismatch($sformatf("value %0d glyph: expected %0d got %0d",
                                                want.value, want.glyph, got_glyph));
                    if (m_tlast !== want.last)
                        note_mismatch($sformatf("value %0d last: expected %0b got %0b",
                                                want.value, want.last, m_tlast));
                end
            end
            if (s_tvalid && s_tready)
                spell_value(s_tdata);
            pending = expected_symbols.size();
        end
    end

endmodule

// ----- tb/sv/tb.sv -----
// Top of the kanji numeral speller testbench: clock, reset, value stimulus and
// random back-pressure; depends on bkn_pkg, binary_to_kanji_numeral and kanji_run_checker.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bkn_pkg::*;

    localparam int RANDOM_PER_PHASE = 37;
    localparam int DIRECTED_COUNT = 23;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [VALUE_W-1:0] s_tdata = '0;   // [31:0] value
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    logic [OUT_W-1:0]   m_tdata;        // [3:0] symbol, [16:4] glyph_index, zero pad
    logic               m_tlast;
    int                 mismatches;
    int                 pending;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;

    // zero, twenty, unit boundaries, dropped ones, written ones before man and oku, maximum
    logic [VALUE_W-1:0] directed_values [DIRECTED_COUNT] = '{
        32'd0, 32'd1, 32'd9, 32'd10, 32'd11, 32'd19, 32'd20, 32'd21, 32'd99,
        32'd100, 32'd110, 32'd1000, 32'd1111, 32'd9999, 32'd10000, 32'd10001,
        32'd11000, 32'd99999999, 32'd100000000, 32'd100010000, 32'd1000000000,
        32'd2000000020, 32'hFFFFFFFF
    };

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    binary_to_kanji_numeral dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    kanji_run_checker checker_i (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .mismatches (mismatches),
        .pending    (pending)
    );

    // random sink back-pressure
    always @(negedge clk)
        m_tready <= ($urandom_range(99) >= recv_stall_pct);

    // one value transfer; entered and left at a falling edge, tvalid kept high on exit
    task automatic send_value(input logic [VALUE_W-1:0] v);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= v;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
    endtask

    // mix of full-range, short, zero-rich and round values
    function automatic logic [VALUE_W-1:0] pick_value();
        logic [63:0] v;
        logic [63:0] scale;
        int d;
        v = 0;
        case ($urandom_range(6))
            0, 1: v = $urandom();
            2: v = $urandom_range(99);
            3: v = $urandom_range(9999);
            4: v = $urandom_range(99999999);
            5:
            begin
                for (int k = 0; k < 8; k++)
                begin
                    d = $urandom_range(3);
                    v = v * 10 + ((d == 0) ? 0 : (d == 1) ? 1 : $urandom_range(9));
                end
                v = v + 64'($urandom_range(42)) * 64'd100000000;
                if (v > 64'hFFFFFFFF)
                    v = v - 64'd100000000;
            end
            default:
            begin
                scale = 1;
                repeat ($urandom_range(9))
                    scale = scale * 10;
                v = scale * $urandom_range(1, 9);
                if (v > 64'hFFFFFFFF)
                    v = scale;
            end
        endcase
        return v[VALUE_W-1:0];
    endfunction

    // stimulus and verdict
    initial
    begin
        repeat (6) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        foreach (directed_values[i])
            send_value(directed_values[i]);
        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 68; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 68; end
                default: begin send_idle_pct = 26; recv_stall_pct = 26; end
            endcase
            repeat (RANDOM_PER_PHASE)
                send_value(pick_value());
            // hold off until every expected symbol has been seen
            wait_drained();
        end
        repeat (100) @(negedge clk);
        if (mismatches == 0 && pending == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

    // watchdog
    initial
    begin
        #5000000;
        $display("tb: errors");
        $finish;
    end

endmodule

// ----- files.f -----
design/bkn_pkg.sv
design/bkn_bcd.sv
design/bkn_spell.sv
design/binary_to_kanji_numeral.sv
tb/sv/kanji_run_checker.sv
tb/sv/tb.sv
